// File: rtl/fac_pkg.sv
// Shared types and constants for the feed-forward audio compressor.
// No dependencies; every other file of the block refers to it by scoped names.
package fac_pkg;

  // sample format and channel count
  localparam int SW       = 24;
  localparam int CHANNELS = 2;

  // shared multiply-accumulate unit
  localparam int MUL_W = 32;
  localparam int ACC_W = 72;

  // wet signal is clamped to this width; beyond it any nonzero mix saturates
  localparam int WET_W = SW + 16;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  // fixed-point constants
  localparam logic [31:0] DB_PER_OCTAVE_Q16 = 32'd394566;
  localparam logic [31:0] OCTAVE_PER_DB_Q24 = 32'd2786635;
  localparam logic [17:0] EXP_K1            = 18'd45554;
  localparam logic [17:0] EXP_K2            = 18'd14824;
  localparam logic [31:0] EXP_K3            = 32'd5158;
  localparam logic [16:0] MIX_FULL          = 17'd65536;

  // register reset values
  localparam logic signed [15:0] THRESHOLD_RESET = -16'sd5120;
  localparam logic [15:0]        RATIO_RESET     = 16'd49152;
  localparam logic [15:0]        ATTACK_RESET    = 16'd65400;
  localparam logic [15:0]        RELEASE_RESET   = 16'd65529;
  localparam logic signed [14:0] MAKEUP_RESET    = 15'sd0;
  localparam logic [16:0]        MIX_RESET       = 17'd65536;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD = 3'd0,
    REG_RATIO     = 3'd1,
    REG_ATTACK    = 3'd2,
    REG_RELEASE   = 3'd3,
    REG_MAKEUP    = 3'd4,
    REG_MIX       = 3'd5
  } reg_idx_t;

  // register file contents handed to the datapath
  typedef struct packed {
    logic signed [15:0] threshold_db;
    logic [15:0]        ratio_slope;
    logic [15:0]        attack_coeff;
    logic [15:0]        release_coeff;
    logic signed [14:0] makeup_db;
    logic [16:0]        mix_amount;
  } cfg_t;

  // sequencer states, one-hot
  typedef enum logic [17:0] {
    S_IDLE = 18'd1 << 0,
    S_NORM = 18'd1 << 1,
    S_SQR  = 18'd1 << 2,
    S_LVL  = 18'd1 << 3,
    S_TGT  = 18'd1 << 4,
    S_ENV1 = 18'd1 << 5,
    S_ENV2 = 18'd1 << 6,
    S_GMUL = 18'd1 << 7,
    S_P1   = 18'd1 << 8,
    S_P2   = 18'd1 << 9,
    S_P3   = 18'd1 << 10,
    S_GSH  = 18'd1 << 11,
    S_W1   = 18'd1 << 12,
    S_W2   = 18'd1 << 13,
    S_M1   = 18'd1 << 14,
    S_M2   = 18'd1 << 15,
    S_M3   = 18'd1 << 16,
    S_FIN  = 18'd1 << 17
  } state_t;

endpackage

// File: rtl/fac_in_if.sv
// Input sample channel: valid/ready handshake with sample, channel and block mark.
// Depends on fac_pkg for the sample width.
interface fac_in_if;
  logic                        valid;
  logic                        ready;
  logic signed [fac_pkg::SW-1:0] sample_in;
  logic                        channel;
  logic                        last_in_block;

  modport source (output valid, sample_in, channel, last_in_block, input ready);
  modport sink   (input valid, sample_in, channel, last_in_block, output ready);
endinterface

// File: rtl/fac_out_if.sv
// Result channel: valid/ready handshake with processed sample and meter data.
// Depends on fac_pkg for the sample width.
interface fac_out_if;
  logic                        valid;
  logic                        ready;
  logic signed [fac_pkg::SW-1:0] sample_out;
  logic                        channel_out;
  logic signed [15:0]          gain_reduction_db;
  logic                        meter_update;

  modport source (output valid, sample_out, channel_out, gain_reduction_db, meter_update,
                  input ready);
  modport sink   (input valid, sample_out, channel_out, gain_reduction_db, meter_update,
                  output ready);
endinterface

// File: rtl/fac_mac.sv
// Shared 32x32 unsigned multiplier with accumulate input and optional 32-bit
// upper-word shift. Combinational; the caller registers the sum. Uses fac_pkg.
module fac_mac (
  input  logic [fac_pkg::MUL_W-1:0] a,
  input  logic [fac_pkg::MUL_W-1:0] b,
  input  logic                      hi,
  input  logic [fac_pkg::ACC_W-1:0] acc_in,
  output logic [fac_pkg::ACC_W-1:0] sum
);

  logic [2*fac_pkg::MUL_W-1:0] prod;
  logic [fac_pkg::ACC_W-1:0]   prod_ext;

  assign prod     = a * b;
  // upper-word partial products land 32 bits up
  assign prod_ext = hi ? fac_pkg::ACC_W'({prod, {fac_pkg::MUL_W{1'b0}}})
                       : fac_pkg::ACC_W'(prod);
  assign sum      = acc_in + prod_ext;

endmodule

// File: rtl/fac_core.sv
// Sequencer and datapath registers of the compressor: level detection, envelope,
// gain and mix, all through one shared fac_mac. Uses fac_pkg, fac_in_if, fac_out_if.
module fac_core (
  input  logic           clk,
  input  logic           rst,
  input  fac_pkg::cfg_t  cfg,
  fac_in_if.sink         in_stream,
  fac_out_if.source      out_stream
);

  localparam int SW    = fac_pkg::SW;
  localparam int ACC_W = fac_pkg::ACC_W;
  localparam int WET_W = fac_pkg::WET_W;
  localparam logic [WET_W-1:0] WET_MAX = WET_W'(1) << (SW + 15);
  localparam logic [55:0]      Y_LIM   = 56'(1) << (SW - 1);

  fac_pkg::state_t state;

  // item registers
  logic          neg;
  logic [SW-1:0] mag;
  logic          ch;
  logic          last;

  // level detection
  logic [31:0]        nm;
  logic [4:0]         p;
  logic [3:0]         iter;
  logic [30:0]        m;
  logic [15:0]        fr;
  logic signed [17:0] level;

  // envelope and gain
  logic [15:0]        target;
  logic [15:0]        coef;
  logic [15:0]        env;
  logic signed [7:0]  n_exp;
  logic [15:0]        frac;
  logic [17:0]        poly;
  logic [37:0]        g;
  logic [WET_W-1:0]   wet;
  logic [ACC_W-1:0]   acc;

  // shared unit
  logic [31:0]      mac_a;
  logic [31:0]      mac_b;
  logic             mac_hi;
  logic [ACC_W-1:0] mac_in;
  logic [ACC_W-1:0] mac_sum;

  fac_mac u_mac (
    .a      (mac_a),
    .b      (mac_b),
    .hi     (mac_hi),
    .acc_in (mac_in),
    .sum    (mac_sum)
  );

  // input magnitude
  logic          x_neg;
  logic [SW-1:0] x_mag;
  assign x_neg = in_stream.sample_in[SW-1];
  assign x_mag = x_neg ? (~in_stream.sample_in + SW'(1)) : in_stream.sample_in;

  // log2 relative to full scale: {p - (SW-1), fr}
  logic signed [6:0]  pd;
  logic signed [22:0] rel;
  logic               rel_neg;
  logic [22:0]        rel_abs;
  logic [16:0]        lvl_mag;
  logic signed [17:0] level_next;
  assign pd         = $signed({2'b00, p}) - 7'sd1 * 7'(SW - 1);
  assign rel        = {pd, fr};
  assign rel_neg    = pd[6];
  assign rel_abs    = rel_neg ? 23'(-rel) : 23'(rel);
  assign lvl_mag    = mac_sum[40:24];
  assign level_next = rel_neg ? -$signed({1'b0, lvl_mag}) : $signed({1'b0, lvl_mag});

  // excess over threshold
  logic signed [18:0] over;
  logic               over_pos;
  assign over     = $signed({level[17], level})
                  - $signed({{3{cfg.threshold_db[15]}}, cfg.threshold_db});
  assign over_pos = !over[18] && (over != 19'sd0);

  // coefficient pick
  logic [15:0] coef_sel;
  assign coef_sel = (target > env) ? cfg.attack_coeff : cfg.release_coeff;

  // gain in dB (makeup minus envelope)
  logic signed [17:0] gdb;
  logic [17:0]        gabs;
  assign gdb  = $signed({{3{cfg.makeup_db[14]}}, cfg.makeup_db}) - $signed({2'b00, env});
  assign gabs = gdb[17] ? 18'(-gdb) : 18'(gdb);

  // log2 gain in Q16, floor
  logic [23:0] q;
  logic [23:0] e;
  assign q = mac_sum[39:16];
  assign e = gdb[17] ? (24'd0 - q) : q;

  // apply integer part of the exponent
  logic [7:0]  n_abs;
  logic [4:0]  n_sh;
  logic [37:0] g_next;
  assign n_abs = 8'd0 - n_exp;
  assign n_sh  = (n_exp > 8'sd20) ? 5'd20 : n_exp[4:0];
  always_comb begin
    if (!n_exp[7]) begin
      g_next = 38'(poly) << n_sh;
    end else if (n_abs >= 8'd63) begin
      g_next = '0;
    end else begin
      g_next = 38'(poly) >> n_abs[5:0];
    end
  end

  // mix clamp and wet clamp
  logic [16:0] mixc;
  logic [55:0] wfull;
  logic [63:0] wet64;
  assign mixc  = (cfg.mix_amount > fac_pkg::MIX_FULL) ? fac_pkg::MIX_FULL : cfg.mix_amount;
  assign wfull = mac_sum[71:16];
  assign wet64 = 64'(wet);

  // output saturation
  logic [55:0]   y;
  logic [55:0]   ysat;
  logic [SW-1:0] res;
  assign y = acc[71:16];
  always_comb begin
    if (neg) begin
      ysat = (y > Y_LIM) ? Y_LIM : y;
      res  = SW'(56'd0 - ysat);
    end else begin
      ysat = (y > Y_LIM - 56'd1) ? (Y_LIM - 56'd1) : y;
      res  = SW'(ysat);
    end
  end

  // operand select for the shared unit
  always_comb begin
    mac_a  = '0;
    mac_b  = '0;
    mac_hi = 1'b0;
    mac_in = '0;
    unique case (state)
      fac_pkg::S_SQR: begin
        mac_a = {1'b0, m};
        mac_b = {1'b0, m};
      end
      fac_pkg::S_LVL: begin
        mac_a  = 32'(rel_abs);
        mac_b  = fac_pkg::DB_PER_OCTAVE_Q16;
        mac_in = ACC_W'(1) << 23;
      end
      fac_pkg::S_TGT: begin
        mac_a = 32'(over[17:0]);
        mac_b = 32'(cfg.ratio_slope);
      end
      fac_pkg::S_ENV1: begin
        mac_a = 32'(coef_sel);
        mac_b = 32'(env);
      end
      fac_pkg::S_ENV2: begin
        mac_a  = 32'(17'h10000 - {1'b0, coef});
        mac_b  = 32'(target);
        mac_in = acc + ACC_W'(32768);
      end
      fac_pkg::S_GMUL: begin
        mac_a  = 32'(gabs);
        mac_b  = fac_pkg::OCTAVE_PER_DB_Q24;
        mac_in = gdb[17] ? ACC_W'(65535) : '0;
      end
      fac_pkg::S_P1: begin
        mac_a = fac_pkg::EXP_K3;
        mac_b = 32'(frac);
      end
      fac_pkg::S_P2, fac_pkg::S_P3: begin
        mac_a = 32'(poly);
        mac_b = 32'(frac);
      end
      fac_pkg::S_W1: begin
        mac_a  = 32'(mag);
        mac_b  = g[31:0];
        mac_in = ACC_W'(32768);
      end
      fac_pkg::S_W2: begin
        mac_a  = 32'(mag);
        mac_b  = 32'(g[37:32]);
        mac_hi = 1'b1;
        mac_in = acc;
      end
      fac_pkg::S_M1: begin
        mac_a  = 32'(mag);
        mac_b  = 32'(MIX_FULL_ext(mixc));
        mac_in = ACC_W'(32768);
      end
      fac_pkg::S_M2: begin
        mac_a  = wet64[31:0];
        mac_b  = 32'(mixc);
        mac_in = acc;
      end
      fac_pkg::S_M3: begin
        mac_a  = wet64[63:32];
        mac_b  = 32'(mixc);
        mac_hi = 1'b1;
        mac_in = acc;
      end
      default: begin
        mac_a = '0;
      end
    endcase
  end

  // dry share of the mix
  function automatic logic [16:0] MIX_FULL_ext(input logic [16:0] mx);
    MIX_FULL_ext = fac_pkg::MIX_FULL - mx;
  endfunction

  assign in_stream.ready = (state == fac_pkg::S_IDLE);

  // sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= fac_pkg::S_IDLE;
      env              <= '0;
      out_stream.valid <= 1'b0;
    end else begin
      // result drained; a new one loaded in S_FIN keeps valid high
      if (out_stream.valid && out_stream.ready && (state != fac_pkg::S_FIN)) begin
        out_stream.valid <= 1'b0;
      end
      unique case (state)
        fac_pkg::S_IDLE: begin
          if (in_stream.valid) begin
            neg    <= x_neg;
            mag    <= x_mag;
            ch     <= in_stream.channel;
            last   <= in_stream.last_in_block;
            nm     <= 32'(x_mag);
            p      <= 5'd31;
            target <= '0;
            state  <= (x_mag == '0) ? fac_pkg::S_ENV1 : fac_pkg::S_NORM;
          end
        end
        fac_pkg::S_NORM: begin
          if (nm[31:28] == 4'd0) begin
            nm <= nm << 4;
            p  <= p - 5'd4;
          end else if (!nm[31]) begin
            nm <= nm << 1;
            p  <= p - 5'd1;
          end else begin
            m     <= nm[31:1];
            iter  <= '0;
            fr    <= '0;
            state <= fac_pkg::S_SQR;
          end
        end
        fac_pkg::S_SQR: begin
          fr   <= {fr[14:0], mac_sum[61]};
          m    <= mac_sum[61] ? mac_sum[61:31] : mac_sum[60:30];
          iter <= iter + 4'd1;
          if (iter == 4'd15) begin
            state <= fac_pkg::S_LVL;
          end
        end
        fac_pkg::S_LVL: begin
          level <= level_next;
          state <= fac_pkg::S_TGT;
        end
        fac_pkg::S_TGT: begin
          target <= over_pos ? mac_sum[31:16] : 16'd0;
          state  <= fac_pkg::S_ENV1;
        end
        fac_pkg::S_ENV1: begin
          coef  <= coef_sel;
          acc   <= mac_sum;
          state <= fac_pkg::S_ENV2;
        end
        fac_pkg::S_ENV2: begin
          env   <= mac_sum[31:16];
          state <= fac_pkg::S_GMUL;
        end
        fac_pkg::S_GMUL: begin
          state <= fac_pkg::S_P1;
        end
        fac_pkg::S_P1: begin
          poly  <= fac_pkg::EXP_K2 + 18'(mac_sum[31:16]);
          state <= fac_pkg::S_P2;
        end
        fac_pkg::S_P2: begin
          poly  <= fac_pkg::EXP_K1 + mac_sum[33:16];
          state <= fac_pkg::S_P3;
        end
        fac_pkg::S_P3: begin
          poly  <= 18'h10000 + mac_sum[33:16];
          state <= fac_pkg::S_GSH;
        end
        fac_pkg::S_GSH: begin
          g     <= g_next;
          state <= fac_pkg::S_W1;
        end
        fac_pkg::S_W1: begin
          acc   <= mac_sum;
          state <= fac_pkg::S_W2;
        end
        fac_pkg::S_W2: begin
          wet   <= (wfull > 56'(WET_MAX)) ? WET_MAX : WET_W'(wfull);
          state <= fac_pkg::S_M1;
        end
        fac_pkg::S_M1, fac_pkg::S_M2: begin
          acc   <= mac_sum;
          state <= (state == fac_pkg::S_M1) ? fac_pkg::S_M2 : fac_pkg::S_M3;
        end
        fac_pkg::S_M3: begin
          acc   <= mac_sum;
          state <= fac_pkg::S_FIN;
        end
        fac_pkg::S_FIN: begin
          // result register free or being drained this cycle
          if (!out_stream.valid || out_stream.ready) begin
            out_stream.valid             <= 1'b1;
            out_stream.sample_out        <= res;
            out_stream.channel_out       <= (fac_pkg::CHANNELS > 1) ? ch : 1'b0;
            out_stream.gain_reduction_db <= 16'd0 - env;
            out_stream.meter_update      <= last;
            state                        <= fac_pkg::S_IDLE;
          end
        end
        default: begin
          state <= fac_pkg::S_IDLE;
        end
      endcase
    end
  end

  // exponent split of the log2 gain, ready for the polynomial steps
  always_ff @(posedge clk) begin
    if (state == fac_pkg::S_GMUL) begin
      n_exp <= $signed(e[23:16]);
      frac  <= e[15:0];
    end
  end

endmodule

// File: rtl/feedforward_audio_compressor_unit.sv
// Feed-forward hard-knee audio compressor with one gain envelope shared by all
// channels; holds the configuration registers and the processing core (uses
// fac_pkg, fac_in_if, fac_out_if, fac_core). Register writes on cfg_we take
// effect at the next clock edge and belong between samples, with none in flight.
// One sample is processed at a time and in_stream.ready is high only while the
// core is idle. A nonzero sample has its magnitude normalized (the number of
// shift steps set by its leading bit), then squaring rounds for the log, one per
// fraction bit, then level and target, then envelope, gain and mix; a zero sample
// skips the log, level and target. The next input transfer can come in the cycle
// after the result is registered, later while a held result waits for ready.
module feedforward_audio_compressor_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [fac_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fac_pkg::CFG_DATA_W-1:0] cfg_data,
  fac_in_if.sink                         in_stream,
  fac_out_if.source                      out_stream
);

  fac_pkg::cfg_t cfg;

  // register writes; unlisted indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold_db  <= fac_pkg::THRESHOLD_RESET;
      cfg.ratio_slope   <= fac_pkg::RATIO_RESET;
      cfg.attack_coeff  <= fac_pkg::ATTACK_RESET;
      cfg.release_coeff <= fac_pkg::RELEASE_RESET;
      cfg.makeup_db     <= fac_pkg::MAKEUP_RESET;
      cfg.mix_amount    <= fac_pkg::MIX_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fac_pkg::REG_THRESHOLD: cfg.threshold_db  <= $signed(cfg_data[15:0]);
        fac_pkg::REG_RATIO:     cfg.ratio_slope   <= cfg_data[15:0];
        fac_pkg::REG_ATTACK:    cfg.attack_coeff  <= cfg_data[15:0];
        fac_pkg::REG_RELEASE:   cfg.release_coeff <= cfg_data[15:0];
        fac_pkg::REG_MAKEUP:    cfg.makeup_db     <= $signed(cfg_data[14:0]);
        fac_pkg::REG_MIX:       cfg.mix_amount    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  fac_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_stream  (in_stream),
    .out_stream (out_stream)
  );

endmodule

// File: tb/tb.sv
// Self-checking testbench for feedforward_audio_compressor_unit.
// Runs a directed table and random samples against a cycle-free predictor.
// Depends on fac_pkg, fac_in_if, fac_out_if and the RTL of the block.
`timescale 1ns / 100ps

module tb;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [fac_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [fac_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  fac_in_if  smp_if ();
  fac_out_if res_if ();

  feedforward_audio_compressor_unit i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_stream(smp_if.sink), .out_stream(res_if.source)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  typedef struct {
    logic signed [fac_pkg::SW-1:0] smp;
    logic                          ch;
    logic signed [15:0]            gr;
    logic                          mtr;
  } comp_res_t;

  // directed row: sample, channel, mark, and an optional typed expectation
  typedef struct {
    logic signed [fac_pkg::SW-1:0] smp;
    logic                          ch;
    logic                          mark;
    bit                            has_exp;
    logic signed [fac_pkg::SW-1:0] exp_smp;
    logic signed [15:0]            exp_gr;
  } row_t;

  // predictor copy of registers and envelope
  fac_pkg::cfg_t pcfg;
  logic [15:0]   env_q;

  comp_res_t exp_q[$];
  comp_res_t typed_q[$];
  bit        typed_flag[$];
  int        errors = 0;
  int        n_checked = 0;
  int        n_sent = 0;
  longint    cycles = 0;

  // level of a nonzero magnitude in dB full scale, Q8.8
  function automatic longint db_level(longint unsigned mag);
    int unsigned p;
    longint unsigned t, m, fr, u;
    longint rel;
    p = 0; t = mag; fr = 0;
    while (t > 1) begin
      t >>= 1;
      p++;
    end
    m = (p <= 30) ? (mag << (30 - p)) : (mag >> (p - 30));
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 30;
      fr <<= 1;
      if (m >= (64'd1 << 31)) begin
        m >>= 1;
        fr |= 1;
      end
    end
    rel = longint'(p) * 65536 + longint'(fr) - longint'(fac_pkg::SW - 1) * 65536;
    if (rel >= 0) begin
      u = (longint'(rel) * 394566 + (64'd1 << 23)) >> 24;
      return longint'(u);
    end
    u = (longint'(-rel) * 394566 + (64'd1 << 23)) >> 24;
    return -longint'(u);
  endfunction

  // linear gain Q16 for a Q8.8 dB value
  function automatic longint unsigned lin_gain(longint gdb);
    longint prod, e;
    longint unsigned u, f, poly, mant;
    int n;
    prod = gdb * 2786635;
    if (prod >= 0) e = prod >>> 16;
    else e = -longint'((longint'(-prod) + 65535) >> 16);
    u = longint'(e + 64 * 65536);
    n = int'(u >> 16) - 64;
    f = u & 16'hFFFF;
    poly = 5158;
    poly = 14824 + ((poly * f) >> 16);
    poly = 45554 + ((poly * f) >> 16);
    mant = 65536 + ((poly * f) >> 16);
    if (n >= 0) return mant << (n > 20 ? 20 : n);
    if (-n >= 63) return 0;
    return mant >> (-n);
  endfunction

  function automatic comp_res_t compress(logic signed [fac_pkg::SW-1:0] x, logic ch,
                                         logic mark);
    comp_res_t r;
    bit neg;
    longint unsigned mag, tgt, c, env, g, wet, y, mx, lim;
    longint over;
    neg = x < 0;
    mag = neg ? longint'(-longint'(x)) : longint'(x);
    tgt = 0;
    if (mag != 0) begin
      over = db_level(mag) - longint'(pcfg.threshold_db);
      if (over > 0) tgt = (longint'(over) * pcfg.ratio_slope) >> 16;
    end
    env = env_q;
    c = (tgt > env) ? pcfg.attack_coeff : pcfg.release_coeff;
    env = (c * env + (65536 - c) * tgt + 32768) >> 16;
    env_q = env[15:0];
    g = lin_gain(longint'(pcfg.makeup_db) - longint'(env_q));
    mx = pcfg.mix_amount > 65536 ? 65536 : pcfg.mix_amount;
    wet = (mag * g + 32768) >> 16;
    y = (mag * (65536 - mx) + wet * mx + 32768) >> 16;
    lim = 64'd1 << (fac_pkg::SW - 1);
    if (neg) begin
      if (y > lim) y = lim;
      r.smp = fac_pkg::SW'(-longint'(y));
    end else begin
      if (y > lim - 1) y = lim - 1;
      r.smp = fac_pkg::SW'(y);
    end
    r.ch  = (fac_pkg::CHANNELS > 1) ? ch : 1'b0;
    r.gr  = 16'(-$signed({1'b0, env_q}));
    r.mtr = mark;
    return r;
  endfunction

  // register write on the plain port, mirrored into the predictor
  task automatic write_reg(fac_pkg::reg_idx_t idx, logic [fac_pkg::CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
    case (idx)
      fac_pkg::REG_THRESHOLD: pcfg.threshold_db  = val[15:0];
      fac_pkg::REG_RATIO:     pcfg.ratio_slope   = val[15:0];
      fac_pkg::REG_ATTACK:    pcfg.attack_coeff  = val[15:0];
      fac_pkg::REG_RELEASE:   pcfg.release_coeff = val[15:0];
      fac_pkg::REG_MAKEUP:    pcfg.makeup_db     = val[14:0];
      fac_pkg::REG_MIX:       pcfg.mix_amount    = val[16:0];
      default: ;
    endcase
  endtask

  // one sample transfer after a random gap; prediction made at acceptance
  task automatic send_sample(logic signed [fac_pkg::SW-1:0] x, logic ch, logic mark,
                             bit typed, comp_res_t tv);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      smp_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    smp_if.valid         <= 1'b1;
    smp_if.sample_in     <= x;
    smp_if.channel       <= ch;
    smp_if.last_in_block <= mark;
    @(posedge clk);
    while (!smp_if.ready) @(posedge clk);
    exp_q.push_back(compress(x, ch, mark));
    typed_q.push_back(tv);
    typed_flag.push_back(typed);
    n_sent++;
  endtask

  // drain: drop valid, wait for every expectation, then let the core settle
  task automatic wait_idle();
    smp_if.valid <= 1'b0;
    while (exp_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // result side: random stall per result, compare at each transfer
  initial begin
    int stall;
    res_if.ready = 1'b0;
    @(negedge rst);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_if.ready <= 1'b1;
      @(posedge clk);
      while (!res_if.valid) @(posedge clk);
      if (exp_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result sample %0d", $time, res_if.sample_out);
      end else begin
        comp_res_t e, tv;
        bit typed;
        e = exp_q.pop_front();
        tv = typed_q.pop_front();
        typed = typed_flag.pop_front();
        if (typed && (tv.smp !== e.smp || tv.gr !== e.gr)) begin
          errors++;
          $display("%0t: table row disagrees with predictor exp %0d/%0d pred %0d/%0d",
                   $time, tv.smp, tv.gr, e.smp, e.gr);
        end
        if (res_if.sample_out !== e.smp || res_if.channel_out !== e.ch ||
            res_if.gain_reduction_db !== e.gr || res_if.meter_update !== e.mtr) begin
          errors++;
          $display("%0t: mismatch exp smp=%0d ch=%0b gr=%0d mtr=%0b",
                   $time, e.smp, e.ch, e.gr, e.mtr,
                   " got smp=%0d ch=%0b gr=%0d mtr=%0b", res_if.sample_out,
                   res_if.channel_out, res_if.gain_reduction_db, res_if.meter_update);
        end
        n_checked++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("tb: failure");
      $finish;
    end
  end

  row_t dir_rows[9] = '{
    '{24'sd0,        1'b0, 1'b0, 1'b1, 24'sd0,        16'sd0},
    '{24'sd1,        1'b1, 1'b0, 1'b0, 24'sd0,        16'sd0},
    '{-24'sd1,       1'b0, 1'b1, 1'b0, 24'sd0,        16'sd0},
    '{24'sd8388607,  1'b1, 1'b0, 1'b0, 24'sd0,        16'sd0},
    '{-24'sd8388608, 1'b0, 1'b0, 1'b0, 24'sd0,        16'sd0},
    '{24'sh555555,   1'b1, 1'b1, 1'b0, 24'sd0,        16'sd0},
    '{24'shAAAAAA,   1'b0, 1'b0, 1'b0, 24'sd0,        16'sd0},
    '{24'sd1000,     1'b1, 1'b0, 1'b0, 24'sd0,        16'sd0},
    '{24'sd0,        1'b0, 1'b1, 1'b0, 24'sd0,        16'sd0}
  };

  function automatic logic signed [fac_pkg::SW-1:0] rand_sample();
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) return 24'sd0;
    if (k == 1) return ($urandom_range(0, 1) != 0) ? 24'sd8388607 : -24'sd8388608;
    if (k < 5) return $signed(fac_pkg::SW'($urandom)) >>> $urandom_range(0, 22);
    return $signed(fac_pkg::SW'($urandom));
  endfunction

  initial begin
    comp_res_t none;
    logic [fac_pkg::CFG_DATA_W-1:0] settings[6][5];
    logic ch;
    none = '{default: '0};
    smp_if.valid = 1'b0;
    smp_if.sample_in = '0;
    smp_if.channel = 1'b0;
    smp_if.last_in_block = 1'b0;
    pcfg = '{fac_pkg::THRESHOLD_RESET, fac_pkg::RATIO_RESET, fac_pkg::ATTACK_RESET,
             fac_pkg::RELEASE_RESET, fac_pkg::MAKEUP_RESET, fac_pkg::MIX_RESET};
    env_q = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset settings; zero sample has no reduction and unity gain
    foreach (dir_rows[i]) begin
      comp_res_t tv;
      tv = none;
      tv.smp = dir_rows[i].exp_smp;
      tv.gr  = dir_rows[i].exp_gr;
      send_sample(dir_rows[i].smp, dir_rows[i].ch, dir_rows[i].mark,
                  dir_rows[i].has_exp, tv);
    end
    wait_idle();

    // directed: coefficient extremes, threshold at -96 dB then 0 dB, mix above full then zero, big makeup
    write_reg(fac_pkg::REG_ATTACK, 17'd0);
    write_reg(fac_pkg::REG_RELEASE, 17'd65535);
    write_reg(fac_pkg::REG_THRESHOLD, 17'sh1A000);
    write_reg(fac_pkg::REG_RATIO, 17'd65535);
    write_reg(fac_pkg::REG_MAKEUP, 17'h03000);
    write_reg(fac_pkg::REG_MIX, 17'h1FFFF);
    foreach (dir_rows[i]) send_sample(dir_rows[i].smp, dir_rows[i].ch, 1'b1, 1'b0, none);
    wait_idle();
    write_reg(fac_pkg::REG_THRESHOLD, 17'd0);
    write_reg(fac_pkg::REG_MAKEUP, 17'h06000);
    write_reg(fac_pkg::REG_MIX, 17'd0);
    send_sample(24'sd8388607, 1'b0, 1'b0, 1'b0, none);
    send_sample(-24'sd8388608, 1'b1, 1'b1, 1'b0, none);
    wait_idle();

    // random phases over a table of settings (threshold, ratio, attack, release, makeup)
    settings = '{
      '{17'h1A000, 17'd65535, 17'd7,     17'd65529, 17'h06800},
      '{17'h1EC00, 17'd49152, 17'd65400, 17'd65529, 17'h00000},
      '{17'h1F000, 17'd0,     17'd65529, 17'd7,     17'h03000},
      '{17'h1D800, 17'd32768, 17'd30000, 17'd60000, 17'h00600},
      '{17'h00000, 17'd65535, 17'd0,     17'd65535, 17'h07FFF},
      '{17'h1C000, 17'd60000, 17'd1000,  17'd65000, 17'h04000}
    };
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(fac_pkg::REG_THRESHOLD, settings[ph][0]);
      write_reg(fac_pkg::REG_RATIO,     settings[ph][1]);
      write_reg(fac_pkg::REG_ATTACK,    settings[ph][2]);
      write_reg(fac_pkg::REG_RELEASE,   settings[ph][3]);
      write_reg(fac_pkg::REG_MAKEUP,    settings[ph][4]);
      write_reg(fac_pkg::REG_MIX, (ph == 3) ? 17'd32768 : 17'($urandom_range(0, 70000)));
      ch = 1'b0;
      for (int i = 0; i < 80; i++) begin
        send_sample(rand_sample(), ch, ($urandom_range(0, 7) == 0), 1'b0, none);
        ch = ($urandom_range(0, 9) == 0) ? ch : ~ch;
      end
      // hold off the sender until every result is back before new settings
      wait_idle();
    end

    $display("tb: %0d samples sent, %0d results checked under reset, two directed",
             n_sent, n_checked);
    $display("tb: and six random register settings with random stalls on both sides");
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
